/* design/vpa_pkg.sv */
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and codes of the partition allocator
// Beat structures, table entry layout, operation and result codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int MAX_PARTS_DEF = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_READ    = 2'd2;
    localparam logic [1:0] FUNC_SPARE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MEM_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY = 2'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] req_size;
        logic [15:0] release_id;
        logic [4:0]  entry_index;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] proc_id;
        logic [4:0]  part_index;
        logic [15:0] part_size;
        logic        part_used;
        logic [5:0]  part_count;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] size;
        logic        used;
        logic [15:0] owner;
    } t_entry;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE       = 4'd0;
    localparam t_op OP_INIT       = 4'd1;
    localparam t_op OP_ACCEPT     = 4'd2;
    localparam t_op OP_SCAN       = 4'd3;
    localparam t_op OP_SHUP_START = 4'd4;
    localparam t_op OP_SHUP       = 4'd5;
    localparam t_op OP_SPLHI      = 4'd6;
    localparam t_op OP_SPLLO      = 4'd7;
    localparam t_op OP_RN_REQ     = 4'd8;
    localparam t_op OP_RN_CAP     = 4'd9;
    localparam t_op OP_RWR        = 4'd10;
    localparam t_op OP_SHDN       = 4'd11;
    localparam t_op OP_RFIN       = 4'd12;
    localparam t_op OP_RD_REQ     = 4'd13;
    localparam t_op OP_OUT_LOAD   = 4'd14;

    typedef logic [2:0] t_res;
    localparam t_res RES_NONE      = 3'd0;
    localparam t_res RES_ALLOC_OK  = 3'd1;
    localparam t_res RES_NO_FIT    = 3'd2;
    localparam t_res RES_FULL      = 3'd3;
    localparam t_res RES_NOT_FOUND = 3'd4;
    localparam t_res RES_REL_OK    = 3'd5;
    localparam t_res RES_BAD_INDEX = 3'd6;
    localparam t_res RES_READ      = 3'd7;

    typedef struct packed {
        t_op  op;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic       is_alloc;
        logic       scan_done;
        logic       found;
        logic       exact;
        logic       full;
        logic       shup_done;
        logic       shdn_done;
        logic       idx_bad;
        logic       out_free;
    } t_stat;

endpackage

/* design/variable_partition_allocator_top.sv */
// ----------------------------------------------------------------------------
// variable_partition_allocator_top: variable-partition memory allocator
// Address-ordered partition table with first, best or worst fit allocation,
// release with merging of free neighbors, and entry readout.
// ----------------------------------------------------------------------------
// Allocate and release scan the table one entry per cycle through the single
// RAM read port, then shift entries one per cycle where needed. One operation
// is in flight at once, and a stalled result holds the next one. After reset
// the INIT state loads entry 0 with the memory size before the first beat is
// taken; configuration writes are accepted from the cycle after.
module variable_partition_allocator_top #(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  vpa_pkg::t_in_beat              i_in_beat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output vpa_pkg::t_out_beat             o_out_beat,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vpa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    vpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    vpa_datapath #(.MAX_PARTS(MAX_PARTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_beat   (i_in_beat),
        .o_out_beat  (o_out_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_beat.func != FUNC_SPARE) |=> o_in_stall)
        else $error("block idle right after accepting an operation");

    a_split_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.op == OP_SPLHI) |-> !w_stat.full)
        else $error("split issued on a full table");

    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status == ST_BAD_INDEX) |->
        (o_out_beat.proc_id == 16'd0 && o_out_beat.part_size == 16'd0))
        else $error("bad index result carries data");
endmodule

/* design/vpa_ram.sv */
// ----------------------------------------------------------------------------
// vpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* design/vpa_datapath.sv */
// ----------------------------------------------------------------------------
// vpa_datapath: partition table, scan unit and result register
// Executes one command per cycle against the partition RAM and keeps the
// configuration, counters and the output beat register.
// ----------------------------------------------------------------------------
module vpa_datapath #(
    parameter int MAX_PARTS = vpa_pkg::MAX_PARTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vpa_pkg::t_cmd                    i_cmd,
    output vpa_pkg::t_stat                   o_stat,
    input  vpa_pkg::t_in_beat                i_in_beat,
    output vpa_pkg::t_out_beat               o_out_beat,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vpa_pkg::*;

    localparam int AW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam int XW = (AW > 5) ? AW : 5;
    localparam int KW = (CW > 6) ? CW : 6;
    localparam int IW = (CW > 5) ? CW : 5;

    logic [15:0]   r_mem_size, n_mem_size;
    logic [1:0]    r_policy, n_policy;
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_next_id, n_next_id;
    logic [1:0]    r_func, n_func;
    logic [15:0]   r_req, n_req;
    logic [15:0]   r_rid, n_rid;
    logic [4:0]    r_idx, n_idx;
    logic [15:0]   r_id, n_id;
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_dv, n_dv;
    logic [AW-1:0] r_ev, n_ev;
    logic          r_found, n_found;
    logic [AW-1:0] r_pick, n_pick;
    logic [15:0]   r_best, n_best;
    t_entry        r_pick_ent, n_pick_ent;
    t_entry        r_last, n_last;
    t_entry        r_prev, n_prev;
    t_entry        r_next, n_next;
    logic          r_has_next, n_has_next;
    logic [CW-1:0] r_sr, n_sr;
    logic [AW-1:0] r_sw, n_sw;
    logic          r_sdv, n_sdv;
    logic [1:0]    r_k, n_k;
    logic [AW-1:0] r_p, n_p;
    logic [15:0]   r_psize, n_psize;
    t_out_beat     r_res, n_res;
    t_out_beat     r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_q;

    logic          cand, left, right, rel_match;
    logic [15:0]   left_amt;
    logic [XW-1:0] idx_x;

    function automatic logic [4:0] idx5(input logic [AW-1:0] a);
        logic [XW-1:0] t;
        t = XW'(a);
        return t[4:0];
    endfunction

    function automatic logic [5:0] cnt6(input logic [CW-1:0] c);
        logic [KW-1:0] t;
        t = KW'(c);
        return t[5:0];
    endfunction

    vpa_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_PARTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign idx_x     = XW'(r_idx);
    assign cand      = (r_req != 16'd0) && !ram_q.used && (ram_q.size >= r_req);
    assign left_amt  = ram_q.size - r_req;
    assign rel_match = ram_q.used && (ram_q.owner == r_rid);
    assign left      = (r_pick != '0) && !r_prev.used;
    assign right     = r_has_next && !r_next.used;

    always_comb begin
        o_stat.in_func   = i_in_beat.func;
        o_stat.is_alloc  = (r_func == FUNC_ALLOC);
        o_stat.scan_done = (r_found && ((r_func != FUNC_ALLOC) ||
                           (r_policy != POL_BEST && r_policy != POL_WORST))) ||
                           ((r_ptr >= r_count) && !r_dv);
        o_stat.found     = r_found;
        o_stat.exact     = (r_pick_ent.size == r_req);
        o_stat.full      = (r_count >= CW'(MAX_PARTS));
        o_stat.shup_done = !(r_sr > CW'(r_pick)) && !r_sdv;
        o_stat.shdn_done = !((r_k != 2'd0) && (r_sr < r_count)) && !r_sdv;
        o_stat.idx_bad   = (IW'(r_idx) >= IW'(r_count));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_mem_size  = r_mem_size;
        n_policy    = r_policy;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_func      = r_func;
        n_req       = r_req;
        n_rid       = r_rid;
        n_idx       = r_idx;
        n_id        = r_id;
        n_ptr       = r_ptr;
        n_dv        = r_dv;
        n_ev        = r_ev;
        n_found     = r_found;
        n_pick      = r_pick;
        n_best      = r_best;
        n_pick_ent  = r_pick_ent;
        n_last      = r_last;
        n_prev      = r_prev;
        n_next      = r_next;
        n_has_next  = r_has_next;
        n_sr        = r_sr;
        n_sw        = r_sw;
        n_sdv       = r_sdv;
        n_k         = r_k;
        n_p         = r_p;
        n_psize     = r_psize;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_raddr   = '0;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '{size: r_mem_size, used: 1'b0, owner: 16'd0};
                n_count   = CW'(1);
            end
            OP_ACCEPT: begin
                n_func  = i_in_beat.func;
                n_req   = i_in_beat.req_size;
                n_rid   = i_in_beat.release_id;
                n_idx   = i_in_beat.entry_index;
                n_ptr   = '0;
                n_dv    = 1'b0;
                n_found = 1'b0;
                if (i_in_beat.func == FUNC_ALLOC) begin
                    n_id      = r_next_id;
                    n_next_id = r_next_id + 16'd1;
                end
            end
            OP_SCAN: begin
                if (r_ptr < r_count) begin
                    ram_raddr = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_dv      = 1'b1;
                    n_ev      = r_ptr[AW-1:0];
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    n_last = ram_q;
                    if (r_func == FUNC_ALLOC) begin
                        if (cand && (!r_found ||
                            (r_policy == POL_BEST && left_amt < r_best) ||
                            (r_policy == POL_WORST && left_amt > r_best))) begin
                            n_found    = 1'b1;
                            n_pick     = r_ev;
                            n_best     = left_amt;
                            n_pick_ent = ram_q;
                        end
                    end else if (rel_match && !r_found) begin
                        n_found    = 1'b1;
                        n_pick     = r_ev;
                        n_pick_ent = ram_q;
                        n_prev     = r_last;
                    end
                end
            end
            OP_SHUP_START: begin
                n_sr  = r_count - CW'(1);
                n_sdv = 1'b0;
            end
            OP_SHUP: begin
                if (r_sr > CW'(r_pick)) begin
                    ram_raddr = r_sr[AW-1:0];
                    n_sr      = r_sr - CW'(1);
                    n_sdv     = 1'b1;
                    n_sw      = AW'(r_sr + CW'(1));
                end else begin
                    n_sdv = 1'b0;
                end
                if (r_sdv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_sw;
                    ram_wdata = ram_q;
                end
            end
            OP_SPLHI: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick + AW'(1);
                ram_wdata = '{size: r_pick_ent.size - r_req, used: 1'b0, owner: 16'd0};
                n_count   = r_count + CW'(1);
            end
            OP_SPLLO: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = '{size: r_req, used: 1'b1, owner: r_id};
            end
            OP_RN_REQ: begin
                ram_raddr  = r_pick + AW'(1);
                n_has_next = (CW'(r_pick) + CW'(1)) < r_count;
            end
            OP_RN_CAP: begin
                n_next = ram_q;
            end
            OP_RWR: begin
                n_p     = left ? (r_pick - AW'(1)) : r_pick;
                n_psize = r_pick_ent.size + (left ? r_prev.size : 16'd0)
                          + (right ? r_next.size : 16'd0);
                n_k     = {1'b0, left} + {1'b0, right};
                n_sr    = CW'(r_pick) + CW'(1) + CW'(right);
                n_sdv   = 1'b0;
                ram_we    = 1'b1;
                ram_waddr = n_p;
                ram_wdata = '{size: n_psize, used: 1'b0, owner: 16'd0};
            end
            OP_SHDN: begin
                if ((r_k != 2'd0) && (r_sr < r_count)) begin
                    ram_raddr = r_sr[AW-1:0];
                    n_sr      = r_sr + CW'(1);
                    n_sdv     = 1'b1;
                    n_sw      = AW'(r_sr - CW'(r_k));
                end else begin
                    n_sdv = 1'b0;
                end
                if (r_sdv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_sw;
                    ram_wdata = ram_q;
                end
            end
            OP_RFIN: begin
                n_count = r_count - CW'(r_k);
            end
            OP_RD_REQ: begin
                ram_raddr = idx_x[AW-1:0];
            end
            OP_OUT_LOAD: begin
                n_out       = r_res;
                n_out_valid = 1'b1;
            end
            default: begin
            end
        endcase

        unique case (i_cmd.res)
            RES_NONE: begin
            end
            RES_ALLOC_OK: begin
                n_res = '{status: ST_OK, proc_id: r_id, part_index: idx5(r_pick),
                          part_size: r_req, part_used: 1'b1, part_count: cnt6(r_count)};
            end
            RES_NO_FIT: begin
                n_res = '{status: ST_NO_FIT, proc_id: r_id, part_index: 5'd0,
                          part_size: 16'd0, part_used: 1'b0, part_count: cnt6(r_count)};
            end
            RES_FULL: begin
                n_res = '{status: ST_FULL, proc_id: r_id, part_index: 5'd0,
                          part_size: 16'd0, part_used: 1'b0, part_count: cnt6(r_count)};
            end
            RES_NOT_FOUND: begin
                n_res = '{status: ST_NOT_FOUND, proc_id: r_rid, part_index: 5'd0,
                          part_size: 16'd0, part_used: 1'b0, part_count: cnt6(r_count)};
            end
            RES_REL_OK: begin
                n_res = '{status: ST_OK, proc_id: r_rid, part_index: idx5(r_p),
                          part_size: r_psize, part_used: 1'b0,
                          part_count: cnt6(r_count - CW'(r_k))};
            end
            RES_BAD_INDEX: begin
                n_res = '{status: ST_BAD_INDEX, proc_id: 16'd0, part_index: 5'd0,
                          part_size: 16'd0, part_used: 1'b0, part_count: cnt6(r_count)};
            end
            RES_READ: begin
                n_res = '{status: ST_OK, proc_id: ram_q.used ? ram_q.owner : 16'd0,
                          part_index: r_idx, part_size: ram_q.size,
                          part_used: ram_q.used, part_count: cnt6(r_count)};
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == REG_MEM_SIZE) begin
                n_mem_size = i_cfg_data;
                n_count    = CW'(1);
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{size: i_cfg_data, used: 1'b0, owner: 16'd0};
            end else if (i_cfg_index == REG_FIT_POLICY) begin
                n_policy = i_cfg_data[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size  <= 16'd1024;
            r_policy    <= 2'd0;
            r_count     <= CW'(1);
            r_next_id   <= 16'd0;
            r_func      <= FUNC_READ;
            r_ptr       <= '0;
            r_dv        <= 1'b0;
            r_found     <= 1'b0;
            r_sr        <= '0;
            r_sdv       <= 1'b0;
            r_k         <= 2'd0;
            r_has_next  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mem_size  <= n_mem_size;
            r_policy    <= n_policy;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_func      <= n_func;
            r_ptr       <= n_ptr;
            r_dv        <= n_dv;
            r_found     <= n_found;
            r_sr        <= n_sr;
            r_sdv       <= n_sdv;
            r_k         <= n_k;
            r_has_next  <= n_has_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rid      <= n_rid;
        r_idx      <= n_idx;
        r_id       <= n_id;
        r_ev       <= n_ev;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_pick_ent <= n_pick_ent;
        r_last     <= n_last;
        r_prev     <= n_prev;
        r_next     <= n_next;
        r_sw       <= n_sw;
        r_p        <= n_p;
        r_psize    <= n_psize;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_beat  = r_out;
    assign o_out_valid = r_out_valid;
endmodule

/* design/vpa_ctrl.sv */
// ----------------------------------------------------------------------------
// vpa_ctrl: operation sequencer of the partition allocator
// Steps each operation through scan, shift, merge and result phases and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module vpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_cfg_ready,
    input  vpa_pkg::t_stat i_stat,
    output vpa_pkg::t_cmd  o_cmd
);
    import vpa_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_ALC_DEC = 4'd3;
    localparam logic [3:0] S_SHUP    = 4'd4;
    localparam logic [3:0] S_SPLHI   = 4'd5;
    localparam logic [3:0] S_SPLLO   = 4'd6;
    localparam logic [3:0] S_REL_DEC = 4'd7;
    localparam logic [3:0] S_RN_CAP  = 4'd8;
    localparam logic [3:0] S_RWR     = 4'd9;
    localparam logic [3:0] S_SHDN    = 4'd10;
    localparam logic [3:0] S_RFIN    = 4'd11;
    localparam logic [3:0] S_RD_DEC  = 4'd12;
    localparam logic [3:0] S_RD_CAP  = 4'd13;
    localparam logic [3:0] S_DONE    = 4'd14;

    logic [3:0] r_state, n_state;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state != S_INIT);

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        o_cmd.res = RES_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    if (i_stat.in_func == FUNC_ALLOC || i_stat.in_func == FUNC_RELEASE) begin
                        n_state = S_SCAN;
                    end else if (i_stat.in_func == FUNC_READ) begin
                        n_state = S_RD_DEC;
                    end
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = i_stat.is_alloc ? S_ALC_DEC : S_REL_DEC;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_ALC_DEC: begin
                priority if (!i_stat.found) begin
                    o_cmd.res = RES_NO_FIT;
                    n_state   = S_DONE;
                end else if (i_stat.exact) begin
                    n_state = S_SPLLO;
                end else if (i_stat.full) begin
                    o_cmd.res = RES_FULL;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = OP_SHUP_START;
                    n_state  = S_SHUP;
                end
            end
            S_SHUP: begin
                if (i_stat.shup_done) begin
                    n_state = S_SPLHI;
                end else begin
                    o_cmd.op = OP_SHUP;
                end
            end
            S_SPLHI: begin
                o_cmd.op = OP_SPLHI;
                n_state  = S_SPLLO;
            end
            S_SPLLO: begin
                o_cmd.op  = OP_SPLLO;
                o_cmd.res = RES_ALLOC_OK;
                n_state   = S_DONE;
            end
            S_REL_DEC: begin
                if (!i_stat.found) begin
                    o_cmd.res = RES_NOT_FOUND;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = OP_RN_REQ;
                    n_state  = S_RN_CAP;
                end
            end
            S_RN_CAP: begin
                o_cmd.op = OP_RN_CAP;
                n_state  = S_RWR;
            end
            S_RWR: begin
                o_cmd.op = OP_RWR;
                n_state  = S_SHDN;
            end
            S_SHDN: begin
                if (i_stat.shdn_done) begin
                    n_state = S_RFIN;
                end else begin
                    o_cmd.op = OP_SHDN;
                end
            end
            S_RFIN: begin
                o_cmd.op  = OP_RFIN;
                o_cmd.res = RES_REL_OK;
                n_state   = S_DONE;
            end
            S_RD_DEC: begin
                if (i_stat.idx_bad) begin
                    o_cmd.res = RES_BAD_INDEX;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = OP_RD_REQ;
                    n_state  = S_RD_CAP;
                end
            end
            S_RD_CAP: begin
                o_cmd.res = RES_READ;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
